FILE: rtl/edl_pkg.sv
package edl_pkg;

    localparam int CHAN_W  = 8;
    localparam int GREY_W  = 8;
    localparam int GAIN_W  = 8;
    localparam int SCORE_W = 10;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 8'd25;
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 10'd1000;

    // frame queue between accumulator and scoring engine
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_LVL_W = 3;

    // fixed-point widths of the scoring engine
    localparam int QUO_W     = 19;   // x in Q16, below 7.0
    localparam int Y_W       = 26;   // x/128 in Q30
    localparam int T_W       = 31;   // series term, up to 1.0 in Q30
    localparam int V_W       = 26;   // term before the divide by k
    localparam int RECIP_W   = 32;
    localparam int PROD_W    = V_W + RECIP_W;
    localparam int ACC_W     = 32;
    localparam int E_W       = 31;
    localparam int TERMS     = 8;
    localparam int SQUARINGS = 7;
    localparam int STEP_W    = 5;
    localparam int K_W       = 3;

    localparam logic [15:0] DEN_SCALE = 16'd65025;
    localparam logic [T_W-1:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic               empty;
        logic [Q_LVL_W-1:0] level;
    } t_q_status;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_TMUL  = 9'b000001000,
        S_RMUL  = 9'b000010000,
        S_CORR  = 9'b000100000,
        S_SQR   = 9'b001000000,
        S_SCALE = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_back_state;

    // floor((2^32-1)/k) for k = kidx+1; quotient is off by at most one
    function automatic logic [RECIP_W-1:0] recip_of(input logic [K_W-1:0] kidx);
        logic [RECIP_W-1:0] m;
        case (kidx)
            3'd0:    m = 32'hFFFF_FFFF;
            3'd1:    m = 32'h7FFF_FFFF;
            3'd2:    m = 32'h5555_5555;
            3'd3:    m = 32'h3FFF_FFFF;
            3'd4:    m = 32'h3333_3333;
            3'd5:    m = 32'h2AAA_AAAA;
            3'd6:    m = 32'h2492_4924;
            default: m = 32'h1FFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/edge_distance_likelihood.sv
// channel  | handshake          | payload
// pixel in | i_valid / o_ready  | i_hyp_{red,green,blue}, i_dist_{red,green,blue}, i_frame_end
// score out| o_valid / i_ready  | o_score, o_empty_frame
// gain cfg | i_cfg_wr_en        | i_cfg_wr_data
//
// pixels enter at one per cycle while o_ready is high; each frame end parks its sums in a 4-entry frame queue
// the scoring engine works on one frame at a time: the divider, then the
// eight series terms (one shared multiply, reciprocal and correction each), then 7 squarings
// frames shorter than the engine's work fill the queue and then hold o_ready low until a slot frees
// the result sits in an output register, so a stalled i_ready only stops the engine's last step
// reset is synchronous, active low, and sets the gain to 25
module edge_distance_likelihood
    import edl_pkg::*;
#(
    parameter int COUNT_BITS = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [GAIN_W-1:0]  i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CHAN_W-1:0]  i_hyp_red,
    input  logic [CHAN_W-1:0]  i_hyp_green,
    input  logic [CHAN_W-1:0]  i_hyp_blue,
    input  logic [CHAN_W-1:0]  i_dist_red,
    input  logic [CHAN_W-1:0]  i_dist_green,
    input  logic [CHAN_W-1:0]  i_dist_blue,
    input  logic               i_frame_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SCORE_W-1:0] o_score,
    output logic               o_empty_frame
);

    localparam int SUM_W = 16 + COUNT_BITS;
    localparam int ENT_W = SUM_W + COUNT_BITS;

    logic [GAIN_W-1:0] r_gain;

    t_q_status             w_q_status;
    logic                  w_push;
    logic                  w_pop;
    logic [SUM_W-1:0]      w_push_sum;
    logic [COUNT_BITS-1:0] w_push_count;
    logic [ENT_W-1:0]      w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    edl_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hyp_red    (i_hyp_red),
        .i_hyp_green  (i_hyp_green),
        .i_hyp_blue   (i_hyp_blue),
        .i_dist_red   (i_dist_red),
        .i_dist_green (i_dist_green),
        .i_dist_blue  (i_dist_blue),
        .i_frame_end  (i_frame_end),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_sum        (w_push_sum),
        .o_count      (w_push_count)
    );

    edl_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data ({w_push_sum, w_push_count}),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_q_status)
    );

    edl_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_gain        (r_gain),
        .i_q_status    (w_q_status),
        .i_head_sum    (w_head[ENT_W-1:COUNT_BITS]),
        .i_head_count  (w_head[COUNT_BITS-1:0]),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_score       (o_score),
        .o_empty_frame (o_empty_frame)
    );

endmodule

FILE: rtl/edl_front.sv
module edl_front
    import edl_pkg::*;
#(
    parameter int  COUNT_BITS = 18,
    localparam int SUM_W      = 16 + COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CHAN_W-1:0]     i_hyp_red,
    input  logic [CHAN_W-1:0]     i_hyp_green,
    input  logic [CHAN_W-1:0]     i_hyp_blue,
    input  logic [CHAN_W-1:0]     i_dist_red,
    input  logic [CHAN_W-1:0]     i_dist_green,
    input  logic [CHAN_W-1:0]     i_dist_blue,
    input  logic                  i_frame_end,
    input  t_q_status             i_q_status,
    output logic                  o_push,
    output logic [SUM_W-1:0]      o_sum,
    output logic [COUNT_BITS-1:0] o_count
);

    localparam int GACC_W = 22;
    localparam logic [GACC_W-1:0] W_RED   = 22'd4899;
    localparam logic [GACC_W-1:0] W_GREEN = 22'd9617;
    localparam logic [GACC_W-1:0] W_BLUE  = 22'd1868;
    localparam logic [GACC_W-1:0] W_ROUND = 22'd8192;

    function automatic logic [GREY_W-1:0] grey_of(input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
        logic [GACC_W-1:0] acc;
        acc = GACC_W'(r) * W_RED + GACC_W'(g) * W_GREEN + GACC_W'(b) * W_BLUE + W_ROUND;
        return acc[GACC_W-1:14];
    endfunction

    logic              r_a_valid;
    logic              r_a_end;
    logic [GREY_W-1:0] r_a_hg;
    logic [GREY_W-1:0] r_a_dg;

    logic [SUM_W-1:0]      r_sum;
    logic [COUNT_BITS-1:0] r_cnt;

    logic [Q_LVL_W-1:0]      w_need;
    logic                    w_take;
    logic [2*GREY_W-1:0]     w_prod;
    logic [SUM_W:0]          w_sum_ext;
    logic [SUM_W-1:0]        w_sum_next;
    logic [COUNT_BITS-1:0]   w_cnt_next;

    // keep a queue slot for the frame end in flight
    assign w_need  = i_q_status.level + Q_LVL_W'(r_a_valid & r_a_end);
    assign o_ready = (w_need < Q_LVL_W'(Q_DEPTH));
    assign w_take  = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a_hg  <= grey_of(i_hyp_red, i_hyp_green, i_hyp_blue);
            r_a_dg  <= grey_of(i_dist_red, i_dist_green, i_dist_blue);
            r_a_end <= i_frame_end;
        end
    end

    assign w_prod     = r_a_hg * r_a_dg;
    assign w_sum_ext  = {1'b0, r_sum} + (SUM_W+1)'(w_prod);
    assign w_sum_next = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
    assign w_cnt_next = (r_a_hg != '0 && r_cnt != '1) ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (r_a_valid) begin
            if (r_a_end) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= w_sum_next;
                r_cnt <= w_cnt_next;
            end
        end
    end

    assign o_push  = r_a_valid & r_a_end;
    assign o_sum   = w_sum_next;
    assign o_count = w_cnt_next;

endmodule

FILE: rtl/edl_queue.sv
module edl_queue
    import edl_pkg::*;
#(
    parameter int WIDTH = 52
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output t_q_status        o_status
);

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_LVL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_level == '0);
    assign o_status.level = r_level;

    // the accumulator must hold back a frame end when no slot is left
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_level < Q_LVL_W'(Q_DEPTH)))
        else $error("frame queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_level != '0))
        else $error("frame queue underflow");

endmodule

FILE: rtl/edl_back.sv
module edl_back
    import edl_pkg::*;
#(
    parameter int  COUNT_BITS = 18,
    localparam int SUM_W      = 16 + COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [GAIN_W-1:0]     i_gain,
    input  t_q_status             i_q_status,
    input  logic [SUM_W-1:0]      i_head_sum,
    input  logic [COUNT_BITS-1:0] i_head_count,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SCORE_W-1:0]    o_score,
    output logic                  o_empty_frame
);

    localparam int NUM_W = SUM_W + GAIN_W;
    localparam int DEN_W = COUNT_BITS + 16;
    localparam int REM_W = DEN_W + 3;

    t_back_state r_state;
    t_back_state n_state;

    logic [NUM_W-1:0]       r_num;
    logic [DEN_W-1:0]       r_den;
    logic [REM_W-1:0]       r_rem;
    logic [QUO_W-1:0]       r_quo;
    logic [STEP_W-1:0]      r_step;
    logic [T_W-1:0]         r_t;
    logic [Y_W-1:0]         r_y;
    logic [V_W-1:0]         r_v;
    logic [PROD_W-1:0]      r_prod;
    logic [K_W-1:0]         r_kidx;
    logic signed [ACC_W-1:0] r_acc;
    logic [E_W-1:0]         r_e;
    logic [SCORE_W-1:0]     r_calc_score;
    logic                   r_calc_empty;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [SCORE_W-1:0]     r_score;
    logic                   r_empty;

    logic [NUM_W-1:0]        w_num;
    logic [DEN_W-1:0]        w_den;
    logic [REM_W-1:0]        w_seven_den;
    logic                    w_too_big;
    logic [DEN_W+1:0]        w_dsr;
    logic                    w_ge;
    logic [REM_W-1:0]        w_rem_sub;
    logic [T_W+Y_W-1:0]      w_tmul;
    logic [V_W-1:0]          w_v;
    logic [PROD_W-1:0]       w_rmul;
    logic [V_W-1:0]          w_q0;
    logic [K_W:0]            w_k;
    logic [V_W+K_W:0]        w_q0k;
    logic [V_W-1:0]          w_rest;
    logic [V_W-1:0]          w_tn;
    logic signed [ACC_W-1:0] w_tn_s;
    logic signed [ACC_W-1:0] w_acc_next;
    logic [E_W-1:0]          w_e_clamp;
    logic [2*E_W-1:0]        w_sq;
    logic [E_W+SCORE_W-1:0]  w_scale;
    logic [SCORE_W:0]        w_scaled;
    logic                    w_load;

    assign o_pop = (r_state == S_IDLE) && !i_q_status.empty;

    assign w_num = i_gain * i_head_sum;
    assign w_den = DEN_SCALE * i_head_count;

    // quotient of num/den reaches 7 exactly when num >= 8*den - den
    assign w_seven_den = {r_den, 3'b000} - {3'b000, r_den};
    assign w_too_big   = (r_num >= NUM_W'(w_seven_den));

    // restoring divide against den*4, one quotient bit a cycle
    assign w_dsr     = {r_den, 2'b00};
    assign w_ge      = (r_rem >= {1'b0, w_dsr});
    assign w_rem_sub = w_ge ? r_rem - {1'b0, w_dsr} : r_rem;

    // taylor term: t*y >> 30, then divide by k through a reciprocal
    assign w_tmul = r_t * r_y;
    assign w_v    = r_prod[30 +: V_W];
    assign w_rmul = w_v * recip_of(r_kidx);
    assign w_q0   = r_prod[RECIP_W +: V_W];
    assign w_k    = {1'b0, r_kidx} + 1'b1;
    assign w_q0k  = w_q0 * w_k;
    assign w_rest = r_v - V_W'(w_q0k);
    assign w_tn   = (w_rest >= V_W'(w_k)) ? w_q0 + 1'b1 : w_q0;
    assign w_tn_s = $signed(ACC_W'(w_tn));

    // odd k subtracts
    assign w_acc_next = r_kidx[0] ? r_acc + w_tn_s : r_acc - w_tn_s;

    always_comb begin
        if (w_acc_next < 0) begin
            w_e_clamp = '0;
        end else if (w_acc_next > $signed(ACC_W'(ONE_Q30))) begin
            w_e_clamp = ONE_Q30;
        end else begin
            w_e_clamp = E_W'(w_acc_next);
        end
    end

    assign w_sq     = r_e * r_e;
    assign w_scale  = r_e * SCORE_MAX;
    assign w_scaled = w_scale[30 +: SCORE_W+1];

    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = (i_head_count == '0) ? S_DONE : S_CHECK;
                end
            end
            S_CHECK: n_state = w_too_big ? S_DONE : S_DIV;
            S_DIV: begin
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_state = S_TMUL;
                end
            end
            S_TMUL:  n_state = S_RMUL;
            S_RMUL:  n_state = S_CORR;
            S_CORR:  n_state = (r_kidx == K_W'(TERMS - 1)) ? S_SQR : S_TMUL;
            S_SQR: begin
                if (r_step == STEP_W'(SQUARINGS - 1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_DONE;
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_num        <= w_num;
                r_den        <= w_den;
                r_calc_score <= '0;
                r_calc_empty <= 1'b1;
            end
            S_CHECK: begin
                r_rem        <= r_num[REM_W-1:0];
                r_quo        <= '0;
                r_step       <= '0;
                r_calc_empty <= 1'b0;
            end
            S_DIV: begin
                r_quo  <= {r_quo[QUO_W-2:0], w_ge};
                r_rem  <= {w_rem_sub[REM_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                r_y    <= {r_quo[QUO_W-2:0], w_ge, 7'b0000000};
                r_t    <= ONE_Q30;
                r_acc  <= $signed(ACC_W'(ONE_Q30));
                r_kidx <= '0;
            end
            S_TMUL: begin
                r_prod <= PROD_W'(w_tmul);
            end
            S_RMUL: begin
                r_prod <= w_rmul;
                r_v    <= w_v;
            end
            S_CORR: begin
                r_t    <= T_W'(w_tn);
                r_acc  <= w_acc_next;
                r_kidx <= r_kidx + 1'b1;
                r_e    <= w_e_clamp;
                r_step <= '0;
            end
            S_SQR: begin
                r_e    <= w_sq[30 +: E_W];
                r_step <= r_step + 1'b1;
            end
            S_SCALE: begin
                r_calc_score <= (w_scaled > (SCORE_W+1)'(SCORE_MAX)) ?
                                SCORE_MAX : w_scaled[SCORE_W-1:0];
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_score <= r_calc_score;
            r_empty <= r_calc_empty;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_score       = r_score;
    assign o_empty_frame = r_empty;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_empty) |-> (r_score == '0))
        else $error("empty frame with non-zero score");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step < STEP_W'(QUO_W)))
        else $error("divider ran past its quotient width");

endmodule

FILE: bench/edge_distance_likelihood_test.sv
`timescale 1ns / 100ps

module edge_distance_likelihood_test
    import edl_pkg::*;
();

    localparam int COUNT_BITS   = 18;
    localparam int SETTLE       = 100;
    localparam int CYCLE_LIMIT  = 1_500_000;

    typedef struct {
        logic [CHAN_W-1:0] hyp_r;
        logic [CHAN_W-1:0] hyp_g;
        logic [CHAN_W-1:0] hyp_b;
        logic [CHAN_W-1:0] dist_r;
        logic [CHAN_W-1:0] dist_g;
        logic [CHAN_W-1:0] dist_b;
        logic              last;
    } t_pixel;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic               empty;
    } t_frame_result;

    class frame_score_tracker;
        localparam bit [63:0] SUM_MAX   = (64'd1 << (16 + COUNT_BITS)) - 64'd1;
        localparam bit [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
        localparam bit [63:0] UNITY_Q30 = 64'd1 << 30;

        bit [63:0]     gain;
        bit [63:0]     product_sum;
        bit [63:0]     nonzero_count;
        t_frame_result pending_scores[$];
        int            mismatches;

        function new();
            gain          = 64'(GAIN_RESET);
            product_sum   = 0;
            nonzero_count = 0;
            mismatches    = 0;
        endfunction

        function bit [63:0] grey_level(bit [63:0] r, bit [63:0] g, bit [63:0] b);
            return (r * 4899 + g * 9617 + b * 1868 + 8192) >> 14;
        endfunction

        // exp(-x) by an 8-term series on x/128, then squared seven times
        function t_frame_result chamfer_score();
            bit [63:0]     num, den, quo, rem, xq, y, t, e, s;
            longint        acc;
            t_frame_result r;
            r.score = '0;
            r.empty = 1'b0;
            if (nonzero_count == 0) begin
                r.empty = 1'b1;
                return r;
            end
            num = gain * product_sum;
            den = 64'd65025 * nonzero_count;
            quo = num / den;
            rem = num % den;
            if (quo >= 7)
                return r;
            xq  = (quo << 16) | ((rem << 16) / den);
            y   = xq << 7;
            t   = UNITY_Q30;
            acc = longint'(UNITY_Q30);
            for (int k = 1; k <= 8; k++) begin
                t = ((t * y) >> 30) / 64'(k);
                if (k % 2 == 1)
                    acc -= longint'(t);
                else
                    acc += longint'(t);
            end
            if (acc < 0)
                acc = 0;
            e = 64'(acc);
            if (e > UNITY_Q30)
                e = UNITY_Q30;
            repeat (7) e = (e * e) >> 30;
            s = (64'd1000 * e) >> 30;
            if (s > 1000)
                s = 1000;
            r.score = s[SCORE_W-1:0];
            return r;
        endfunction

        function void note_pixel(t_pixel px);
            bit [63:0] hg, dg, prod;
            hg   = grey_level(64'(px.hyp_r), 64'(px.hyp_g), 64'(px.hyp_b));
            dg   = grey_level(64'(px.dist_r), 64'(px.dist_g), 64'(px.dist_b));
            prod = hg * dg;
            if (product_sum > SUM_MAX - prod)
                product_sum = SUM_MAX;
            else
                product_sum += prod;
            if (hg != 0 && nonzero_count < COUNT_MAX)
                nonzero_count++;
            if (px.last) begin
                pending_scores.push_back(chamfer_score());
                product_sum   = 0;
                nonzero_count = 0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [SCORE_W-1:0] score, logic empty);
            t_frame_result want;
            if (pending_scores.size() == 0) begin
                report_mismatch($sformatf("score %0d with no frame pending", score));
                return;
            end
            want = pending_scores.pop_front();
            if (score !== want.score)
                report_mismatch($sformatf("score got %0d want %0d", score, want.score));
            if (empty !== want.empty)
                report_mismatch($sformatf("empty_frame got %0b want %0b", empty, want.empty));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [GAIN_W-1:0]  i_cfg_wr_data;
    logic               i_valid;
    logic               o_ready;
    logic [CHAN_W-1:0]  i_hyp_red;
    logic [CHAN_W-1:0]  i_hyp_green;
    logic [CHAN_W-1:0]  i_hyp_blue;
    logic [CHAN_W-1:0]  i_dist_red;
    logic [CHAN_W-1:0]  i_dist_green;
    logic [CHAN_W-1:0]  i_dist_blue;
    logic               i_frame_end;
    logic               o_valid;
    logic               i_ready;
    logic [SCORE_W-1:0] o_score;
    logic               o_empty_frame;

    frame_score_tracker tracker;
    int                 idle_pct;
    int                 stall_pct;
    int                 cycles;

    edge_distance_likelihood #(
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hyp_red    (i_hyp_red),
        .i_hyp_green  (i_hyp_green),
        .i_hyp_blue   (i_hyp_blue),
        .i_dist_red   (i_dist_red),
        .i_dist_green (i_dist_green),
        .i_dist_blue  (i_dist_blue),
        .i_frame_end  (i_frame_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_score      (o_score),
        .o_empty_frame(o_empty_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_result(o_score, o_empty_frame);
    end

    task automatic send_pixel(input t_pixel px);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hyp_red    <= px.hyp_r;
        i_hyp_green  <= px.hyp_g;
        i_hyp_blue   <= px.hyp_b;
        i_dist_red   <= px.dist_r;
        i_dist_green <= px.dist_g;
        i_dist_blue  <= px.dist_b;
        i_frame_end  <= px.last;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_pixel(px);
    endtask

    task automatic send_fields(input int hr, input int hg, input int hb,
                               input int dr, input int dg, input int db, input bit last);
        t_pixel px;
        px.hyp_r  = CHAN_W'(hr);
        px.hyp_g  = CHAN_W'(hg);
        px.hyp_b  = CHAN_W'(hb);
        px.dist_r = CHAN_W'(dr);
        px.dist_g = CHAN_W'(dg);
        px.dist_b = CHAN_W'(db);
        px.last   = last;
        send_pixel(px);
    endtask

    // sender goes quiet until every pending score is back, then idles for as long as extra asks
    task automatic drain_scores(input int extra);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.pending_scores.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.gain = 64'(value);
    endtask

    function automatic t_pixel random_pixel(input int dist_top, input logic last);
        t_pixel px;
        int     pick;
        pick = $urandom_range(9);
        if (pick < 2) begin
            px.hyp_r = '0;
            px.hyp_g = '0;
            px.hyp_b = '0;
        end else if (pick == 2) begin
            // channels of zero or one whose grey still rounds to zero
            px.hyp_r = CHAN_W'($urandom_range(1));
            px.hyp_g = '0;
            px.hyp_b = CHAN_W'($urandom_range(1));
        end else if (pick == 3) begin
            px.hyp_r = 8'hFF;
            px.hyp_g = 8'hFF;
            px.hyp_b = 8'hFF;
        end else begin
            px.hyp_r = CHAN_W'($urandom_range(255));
            px.hyp_g = CHAN_W'($urandom_range(255));
            px.hyp_b = CHAN_W'($urandom_range(255));
        end
        px.dist_r = CHAN_W'($urandom_range(dist_top));
        px.dist_g = CHAN_W'($urandom_range(dist_top));
        px.dist_b = CHAN_W'($urandom_range(dist_top));
        px.last   = last;
        return px;
    endfunction

    task automatic random_frames(input int n_items);
        int sent;
        int len;
        int dist_top;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(40, 9);
            case ($urandom_range(3))
                0:       dist_top = 3;
                1:       dist_top = 15;
                2:       dist_top = 60;
                default: dist_top = 255;
            endcase
            for (int i = 0; i < len; i++)
                send_pixel(random_pixel(dist_top, i == len - 1));
            sent += len;
        end
    endtask

    initial begin
        tracker       = new();
        cycles        = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_hyp_red     = '0;
        i_hyp_green   = '0;
        i_hyp_blue    = '0;
        i_dist_red    = '0;
        i_dist_green  = '0;
        i_dist_blue   = '0;
        i_frame_end   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset gain: zero distance, clamped exponent, empty frames, mixed frames
        send_fields(255, 255, 255,   0,   0,   0, 1);
        send_fields(255, 255, 255, 255, 255, 255, 1);
        send_fields(  0,   0,   0, 255, 255, 255, 0);
        send_fields(  0,   0,   0, 128,   0,   0, 1);
        send_fields(  1,   0,   1, 255, 255, 255, 1);
        send_fields( 10,  10,  10,  12,  12,  12, 0);
        send_fields(  0,   0,   0, 255,   0,   0, 0);
        send_fields(200,   0,   0,   0,   0,   5, 0);
        send_fields(  0, 200,   0,   3,   0,   0, 1);
        send_fields(255,   0,   0,   0, 255,   0, 0);
        send_fields(  0,   0, 255,   0,   0, 255, 0);
        send_fields(  0, 255,   0,   9,   9,   9, 1);
        send_fields(128,  64,  32,  16,   8,   4, 1);
        send_fields(127, 127, 127,   1,   2,   4, 0);
        send_fields( 85, 170,  85,  32,  64, 128, 0);
        send_fields(170,  85, 170,   2,   1,   0, 1);
        send_fields(  1,   1,   1,   1,   1,   1, 1);
        send_fields(255, 255, 255,  20,  20,  20, 0);
        send_fields(255, 255, 255,  40,  40,  40, 1);

        drain_scores(SETTLE);
        write_gain(8'd0);
        idle_pct = 69;
        random_frames(210);

        drain_scores(SETTLE);
        write_gain(8'd255);
        idle_pct  = 0;
        stall_pct = 69;
        random_frames(210);

        drain_scores(SETTLE);
        write_gain(GAIN_W'($urandom_range(254, 2)));
        idle_pct  = 26;
        stall_pct = 26;
        random_frames(210);

        drain_scores(SETTLE);
        write_gain(8'd1);
        idle_pct  = 0;
        stall_pct = 0;
        random_frames(110);
        drain_scores(0);
        random_frames(110);

        drain_scores(SETTLE);
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
